@@ hw/rtl/rpa_pkg.sv @@
// shared types, codes and constants of the refcounted pool allocator
package rpa_pkg;

  localparam int DEF_POOL_DEPTH   = 8;
  localparam int ENTRY_W          = 3;
  localparam int COUNT_W          = 4;
  localparam int FREE_W           = 4;
  localparam int SHARE_KEEP_LIMIT = 2;
  localparam int CLIENT_RESET     = 1;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_NOTIFY  = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [ENTRY_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ENTRY_W-1:0] entry_out;
    logic               released;
    logic [FREE_W-1:0]  free_entries;
  } rsp_t;

endpackage

@@ hw/rtl/rpa_chan_if.sv @@
// valid/ready channel carrying one payload item
interface rpa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/refcounted_pool_allocator.sv @@
// top level of the refcounted pool allocator
//
// pool of POOL_DEPTH entries handed out through a last-in first-out free
// list; every request gets exactly one response. allocate pops the list
// head, release pushes an entry back once its share count is below two
// (else it only decrements the count), notify loads the share count with
// client_count. release or notify of an entry that is not allocated
// answers with status "not allocated" and leaves the pool alone. each
// request reads the link and share-count memories, then modifies, writes
// back and loads the response register; no new request is taken until the
// previous one has written back, while the response register can still
// hold the previous result. the write-back stalls only when the response
// register is full and not being drained. link memory entries that were
// never written read as their reset chain value through a row of per-entry
// written flags, so no clearing pass follows reset.
// client_count may be written at any time the block is idle.
module refcounted_pool_allocator #(
  parameter int POOL_DEPTH = rpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rpa_pkg::COUNT_W-1:0]  cfg_wdata,
  rpa_chan_if.sink                     req,
  rpa_chan_if.source                   rsp
);
  import rpa_pkg::*;

  // address width, free count width and extension widths
  localparam int AW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW  = $clog2(POOL_DEPTH + 1);
  localparam int XW  = (AW > ENTRY_W) ? AW : ENTRY_W;
  localparam int FXW = (CW > FREE_W) ? CW : FREE_W;

  // control state
  state_t                state;
  state_t                state_next;
  logic [AW-1:0]         free_head;
  logic [CW-1:0]         free_total;
  logic [POOL_DEPTH-1:0] in_use;
  logic [POOL_DEPTH-1:0] link_ok;
  logic [COUNT_W-1:0]    client_count;
  logic                  rsp_valid;
  rsp_t                  rsp_data;

  // captured request
  mode_t                 op_mode;
  logic [ENTRY_W-1:0]    op_idx;

  // handshakes
  logic                  accept;
  logic                  exec_go;

  // memory ports
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [AW-1:0]         link_wdata;
  logic [AW-1:0]         link_rdata;
  logic                  share_we;
  logic [AW-1:0]         share_waddr;
  logic [COUNT_W-1:0]    share_wdata;
  logic [COUNT_W-1:0]    share_rdata;

  // request address decode
  logic [XW-1:0]         req_idx_x;
  logic [AW-1:0]         req_addr;
  logic [XW-1:0]         op_idx_x;
  logic [AW-1:0]         op_addr;
  logic                  op_owned;
  logic [XW-1:0]         head_x;
  logic [AW-1:0]         pop_link;
  logic                  pool_empty;

  // next values computed in the modify cycle
  logic [AW-1:0]         head_next;
  logic [CW-1:0]         total_next;
  logic                  use_set;
  logic                  use_clr;
  logic [AW-1:0]         use_addr;
  status_t               res_status;
  logic [ENTRY_W-1:0]    res_entry;
  logic                  res_released;
  logic [FXW-1:0]        total_next_x;

  // fsm: idle takes a request, exec writes back and loads the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    exec_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for room in the response register
        if (!rsp_valid || rsp.ready) begin
          exec_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  // address of the requested entry, zero extended or truncated to the pool
  assign req_idx_x = XW'(req.payload.entry_index);
  assign req_addr  = req_idx_x[AW-1:0];
  assign op_idx_x  = XW'(op_idx);
  assign op_addr   = op_idx_x[AW-1:0];
  assign head_x    = XW'(free_head);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= req.payload.mode;
      op_idx  <= req.payload.entry_index;
    end
  end

  // link memory: read at the list head, written on a push
  rpa_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (AW),
    .AW    (AW)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (accept),
    .rd_addr (free_head),
    .rd_data (link_rdata)
  );

  // share count memory: read at the requested entry; in_use marks live rows
  rpa_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (COUNT_W),
    .AW    (AW)
  ) u_share_ram (
    .clk     (clk),
    .wr_en   (share_we),
    .wr_addr (share_waddr),
    .wr_data (share_wdata),
    .rd_en   (accept),
    .rd_addr (req_addr),
    .rd_data (share_rdata)
  );

  // an unwritten link still holds its reset chain value: entry i to i-1
  always_comb begin
    if (link_ok[free_head]) begin
      pop_link = link_rdata;
    end else if (free_head == '0) begin
      pop_link = '0;
    end else begin
      pop_link = free_head - AW'(1);
    end
  end

  assign pool_empty = (free_total == '0);
  assign op_owned   = (32'(op_idx) < POOL_DEPTH) && in_use[op_addr];

  // modify step
  always_comb begin
    head_next    = free_head;
    total_next   = free_total;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    use_addr     = op_addr;
    link_we      = 1'b0;
    link_waddr   = op_addr;
    link_wdata   = pool_empty ? '0 : free_head;
    share_we     = 1'b0;
    share_waddr  = op_addr;
    share_wdata  = '0;
    res_status   = STAT_OK;
    res_entry    = op_idx;
    res_released = 1'b0;
    case (op_mode)
      MODE_ALLOC: begin
        if (pool_empty) begin
          res_status = STAT_EMPTY;
          res_entry  = '0;
        end else begin
          // pop the head and start it with a zero share count
          res_entry   = head_x[ENTRY_W-1:0];
          head_next   = pop_link;
          total_next  = free_total - CW'(1);
          use_set     = 1'b1;
          use_addr    = free_head;
          share_we    = 1'b1;
          share_waddr = free_head;
        end
      end
      MODE_RELEASE: begin
        if (!op_owned) begin
          res_status = STAT_NOT_ALLOC;
        end else if (share_rdata < COUNT_W'(SHARE_KEEP_LIMIT)) begin
          // last holder: push back on the list head
          link_we      = 1'b1;
          head_next    = op_addr;
          total_next   = free_total + CW'(1);
          use_clr      = 1'b1;
          share_we     = 1'b1;
          res_released = 1'b1;
        end else begin
          share_we    = 1'b1;
          share_wdata = share_rdata - COUNT_W'(1);
        end
      end
      MODE_NOTIFY: begin
        if (!op_owned) begin
          res_status = STAT_NOT_ALLOC;
        end else begin
          share_we    = 1'b1;
          share_wdata = client_count;
        end
      end
      default: begin
        // reserved mode answers ok and changes nothing
        res_status = STAT_OK;
      end
    endcase
    if (!exec_go) begin
      link_we  = 1'b0;
      share_we = 1'b0;
    end
  end

  assign total_next_x = FXW'(total_next);

  // free list head, count and per-entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= AW'(POOL_DEPTH - 1);
      free_total <= CW'(POOL_DEPTH);
      in_use     <= '0;
      link_ok    <= '0;
    end else if (exec_go) begin
      free_head  <= head_next;
      free_total <= total_next;
      if (use_set) begin
        in_use[use_addr] <= 1'b1;
      end
      if (use_clr) begin
        in_use[use_addr] <= 1'b0;
      end
      if (link_we) begin
        link_ok[link_waddr] <= 1'b1;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      client_count <= COUNT_W'(CLIENT_RESET);
    end else if (cfg_we) begin
      client_count <= cfg_wdata;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_data.status       <= res_status;
      rsp_data.entry_out    <= res_entry;
      rsp_data.released     <= res_released;
      rsp_data.free_entries <= total_next_x[FREE_W-1:0];
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  // every entry is either free or in use
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    32'($countones(in_use)) == POOL_DEPTH - 32'(free_total))
    else $error("in-use flags disagree with free count");

  // a successful allocate never hands out a live entry
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    exec_go && op_mode == MODE_ALLOC && !pool_empty |-> !in_use[free_head])
    else $error("allocate popped an entry already in use");

  // a release that frees an entry puts it at the list head
  a_release_push: assert property (@(posedge clk) disable iff (rst)
    exec_go && res_released |=> free_head == $past(op_addr) &&
    free_total == $past(free_total) + CW'(1))
    else $error("release did not push the entry");

  // a new request is taken only after the previous one wrote back
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while another is in flight");

endmodule

@@ hw/rtl/rpa_ram.sv @@
// single-port-write, single-port-read memory with registered read data
module rpa_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 4,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
